// File: sv/q24_pkg.sv
// Shared types, command codes and defaults for the Q24.8 fixed-point ALU.
// No dependencies; every other file imports this package.
package q24_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int CMD_BITS      = 4;
    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [CMD_BITS-1:0] CMD_ADD      = 4'd0;
    localparam logic [CMD_BITS-1:0] CMD_SUB      = 4'd1;
    localparam logic [CMD_BITS-1:0] CMD_MUL      = 4'd2;
    localparam logic [CMD_BITS-1:0] CMD_DIV      = 4'd3;
    localparam logic [CMD_BITS-1:0] CMD_INC      = 4'd4;
    localparam logic [CMD_BITS-1:0] CMD_DEC      = 4'd5;
    localparam logic [CMD_BITS-1:0] CMD_GT       = 4'd6;
    localparam logic [CMD_BITS-1:0] CMD_LT       = 4'd7;
    localparam logic [CMD_BITS-1:0] CMD_LE       = 4'd8;
    localparam logic [CMD_BITS-1:0] CMD_GE       = 4'd9;
    localparam logic [CMD_BITS-1:0] CMD_NE       = 4'd10;
    localparam logic [CMD_BITS-1:0] CMD_EQ       = 4'd11;
    localparam logic [CMD_BITS-1:0] CMD_MIN      = 4'd12;
    localparam logic [CMD_BITS-1:0] CMD_MAX      = 4'd13;
    localparam logic [CMD_BITS-1:0] CMD_FROM_INT = 4'd14;
    localparam logic [CMD_BITS-1:0] CMD_TO_INT   = 4'd15;

    typedef struct packed {
        logic [CMD_BITS-1:0]          command;
        logic signed [FIELD_BITS-1:0] operand_a;
        logic signed [FIELD_BITS-1:0] operand_b;
    } in_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] result;
        logic                         compare_true;
        logic                         overflow;
        logic                         divide_by_zero;
    } out_t;

    // Everything that rides alongside the divider.
    typedef struct packed {
        logic                         is_div;
        logic signed [FIELD_BITS-1:0] result;
        logic                         cmp;
        logic                         ovf;
        logic                         dz;
    } side_t;

endpackage

// File: sv/q24_front.sv
// Front end of the ALU: input register, simple ops and product, multiply rounding.
// Depends on q24_pkg; feeds q24_div_pipe.
module q24_front #(
    parameter int FRAC_BITS = q24_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = q24_pkg::WORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  q24_pkg::in_t            in_data,
    output logic                    out_valid,
    output q24_pkg::side_t          out_side,
    output logic [((WORD_BITS < 32) ? WORD_BITS : 32) + FRAC_BITS:0] out_num,
    output logic [((WORD_BITS < 32) ? WORD_BITS : 32)-1:0]             out_den,
    output logic                    out_neg
);
    import q24_pkg::*;

    localparam int W  = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int NW = W + FRAC_BITS + 1;
    localparam int SW = W + FRAC_BITS;
    localparam int PW = 2 * W;

    // stage 1
    logic                    v1_reg;
    logic [CMD_BITS-1:0]     cmd1_reg;
    logic signed [W-1:0]     a1_reg;
    logic signed [W-1:0]     b1_reg;

    // stage 2
    logic                    v2_reg;
    logic [CMD_BITS-1:0]     cmd2_reg;
    logic signed [W-1:0]     r2_reg;
    logic                    cmp2_reg;
    logic                    ovf2_reg;
    logic signed [PW-1:0]    prod2_reg;
    logic [NW-1:0]           num2_reg;
    logic [W-1:0]            den2_reg;
    logic                    neg2_reg;
    logic                    dz2_reg;

    // stage 3
    logic                    v3_reg;
    side_t                   side3_reg;
    logic [NW-1:0]           num3_reg;
    logic [W-1:0]            den3_reg;
    logic                    neg3_reg;

    logic signed [W:0]       a_ext;
    logic signed [W:0]       b_ext;
    logic signed [W:0]       wide;
    logic                    use_wide;
    logic signed [W-1:0]     r2_next;
    logic                    cmp2_next;
    logic                    ovf2_next;
    logic [W-1:0]            mag_a;
    logic [W-1:0]            mag_b;
    logic [SW-1:0]           shifted;
    logic [SW-1:0]           sh_lim;
    logic [W-1:0]            to_int_mag;

    logic [PW-1:0]           mag_p;
    logic [PW-1:0]           m_rnd;
    logic [PW-1:0]           m_lim;
    logic                    p_neg;
    logic signed [W-1:0]     r3;
    logic                    ovf3;

    always_comb begin
        a_ext      = {a1_reg[W-1], a1_reg};
        b_ext      = {b1_reg[W-1], b1_reg};
        mag_a      = a1_reg[W-1] ? W'(-a1_reg) : W'(a1_reg);
        mag_b      = b1_reg[W-1] ? W'(-b1_reg) : W'(b1_reg);
        shifted    = SW'(mag_a) << FRAC_BITS;
        sh_lim     = a1_reg[W-1] ? (SW'(1) << (W-1)) : ((SW'(1) << (W-1)) - SW'(1));
        to_int_mag = mag_a >> FRAC_BITS;
        wide       = '0;
        use_wide   = 1'b0;
        r2_next    = '0;
        cmp2_next  = 1'b0;
        ovf2_next  = 1'b0;
        unique case (cmd1_reg)
            CMD_ADD: begin
                wide = a_ext + b_ext; use_wide = 1'b1;
            end
            CMD_SUB: begin
                wide = a_ext - b_ext; use_wide = 1'b1;
            end
            CMD_INC: begin
                wide = a_ext + (W+1)'(1); use_wide = 1'b1;
            end
            CMD_DEC: begin
                wide = a_ext - (W+1)'(1); use_wide = 1'b1;
            end
            CMD_GT:  cmp2_next = a1_reg >  b1_reg;
            CMD_LT:  cmp2_next = a1_reg <  b1_reg;
            CMD_LE:  cmp2_next = a1_reg <= b1_reg;
            CMD_GE:  cmp2_next = a1_reg >= b1_reg;
            CMD_NE:  cmp2_next = a1_reg != b1_reg;
            CMD_EQ:  cmp2_next = a1_reg == b1_reg;
            CMD_MIN: r2_next = (a1_reg < b1_reg) ? a1_reg : b1_reg;
            CMD_MAX: r2_next = (a1_reg > b1_reg) ? a1_reg : b1_reg;
            CMD_FROM_INT: begin
                if (shifted > sh_lim) begin
                    ovf2_next = 1'b1;
                    r2_next   = a1_reg[W-1] ? signed'({1'b1, {(W-1){1'b0}}})
                                            : signed'({1'b0, {(W-1){1'b1}}});
                end else begin
                    r2_next = a1_reg[W-1] ? signed'(W'(-shifted[W-1:0]))
                                          : signed'(shifted[W-1:0]);
                end
            end
            CMD_TO_INT: begin
                r2_next = a1_reg[W-1] ? signed'(W'(-to_int_mag)) : signed'(to_int_mag);
            end
            CMD_MUL: r2_next = '0;
            CMD_DIV: r2_next = '0;
        endcase
        // saturate the one-bit-grown sum
        if (use_wide) begin
            if (wide[W] != wide[W-1]) begin
                ovf2_next = 1'b1;
                r2_next   = wide[W] ? signed'({1'b1, {(W-1){1'b0}}})
                                    : signed'({1'b0, {(W-1){1'b1}}});
            end else begin
                r2_next = wide[W-1:0];
            end
        end
    end

    always_comb begin
        p_neg = prod2_reg[PW-1];
        mag_p = p_neg ? PW'(-prod2_reg) : PW'(prod2_reg);
        m_rnd = (mag_p + (PW'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
        m_lim = p_neg ? (PW'(1) << (W-1)) : ((PW'(1) << (W-1)) - PW'(1));
        ovf3  = 1'b0;
        if (m_rnd > m_lim) begin
            ovf3 = 1'b1;
            r3   = p_neg ? signed'({1'b1, {(W-1){1'b0}}}) : signed'({1'b0, {(W-1){1'b1}}});
        end else begin
            r3 = p_neg ? signed'(W'(-m_rnd[W-1:0])) : signed'(m_rnd[W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg  <= in_data.command;
            a1_reg    <= in_data.operand_a[W-1:0];
            b1_reg    <= in_data.operand_b[W-1:0];

            cmd2_reg  <= cmd1_reg;
            r2_reg    <= r2_next;
            cmp2_reg  <= cmp2_next;
            ovf2_reg  <= ovf2_next;
            prod2_reg <= PW'(a1_reg) * PW'(b1_reg);
            num2_reg  <= NW'({mag_a, {FRAC_BITS{1'b0}}}) + NW'(mag_b >> 1);
            den2_reg  <= mag_b;
            neg2_reg  <= a1_reg[W-1] != b1_reg[W-1];
            dz2_reg   <= (cmd1_reg == CMD_DIV) && (b1_reg == '0);

            side3_reg.is_div <= cmd2_reg == CMD_DIV;
            side3_reg.result <= FIELD_BITS'((cmd2_reg == CMD_MUL) ? r3 : r2_reg);
            side3_reg.cmp    <= cmp2_reg;
            side3_reg.ovf    <= (cmd2_reg == CMD_MUL) ? ovf3 : ovf2_reg;
            side3_reg.dz     <= dz2_reg;
            num3_reg         <= num2_reg;
            den3_reg         <= den2_reg;
            neg3_reg         <= neg2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign out_num   = num3_reg;
    assign out_den   = den3_reg;
    assign out_neg   = neg3_reg;

endmodule

// File: sv/q24_div_pipe.sv
// Restoring divider, one quotient bit per pipeline stage, with sideband.
// Depends on q24_pkg for the sideband type.
module q24_div_pipe #(
    parameter int FRAC_BITS = q24_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = q24_pkg::WORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  q24_pkg::side_t          in_side,
    input  logic [((WORD_BITS < 32) ? WORD_BITS : 32) + FRAC_BITS:0] in_num,
    input  logic [((WORD_BITS < 32) ? WORD_BITS : 32)-1:0]             in_den,
    input  logic                    in_neg,
    output logic                    out_valid,
    output q24_pkg::side_t          out_side,
    output logic [((WORD_BITS < 32) ? WORD_BITS : 32) + FRAC_BITS:0] out_quo,
    output logic                    out_neg
);
    import q24_pkg::*;

    localparam int W  = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int NW = W + FRAC_BITS + 1;

    logic          v_reg    [NW];
    side_t         side_reg [NW];
    logic [W-1:0]  rem_reg  [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [W-1:0]  den_reg  [NW];
    logic          neg_reg  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          pv;
        side_t         pside;
        logic [W-1:0]  prem;
        logic [NW-1:0] pnq;
        logic [W-1:0]  pden;
        logic          pneg;
        logic [W:0]    trial;
        logic          take;

        if (k == 0) begin : g_first
            assign pv    = in_valid;
            assign pside = in_side;
            assign prem  = '0;
            assign pnq   = in_num;
            assign pden  = in_den;
            assign pneg  = in_neg;
        end else begin : g_next
            assign pv    = v_reg[k-1];
            assign pside = side_reg[k-1];
            assign prem  = rem_reg[k-1];
            assign pnq   = nq_reg[k-1];
            assign pden  = den_reg[k-1];
            assign pneg  = neg_reg[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign trial = {prem, pnq[NW-1]};
        assign take  = trial >= {1'b0, pden};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= pside;
                rem_reg[k]  <= take ? W'(trial - {1'b0, pden}) : trial[W-1:0];
                nq_reg[k]   <= {pnq[NW-2:0], take};
                den_reg[k]  <= pden;
                neg_reg[k]  <= pneg;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign out_side  = side_reg[NW-1];
    assign out_quo   = nq_reg[NW-1];
    assign out_neg   = neg_reg[NW-1];

endmodule

// File: sv/q24_8_fixed_point_alu.sv
// Q24.8 fixed-point ALU, fully pipelined: one transfer in and one out per cycle
// while results are taken. Every command passes through the same stages; the
// divider's one quotient bit per stage sets the pipeline depth.
// Throughput: one item per cycle while the result side takes transfers.
// Reset (aresetn, synchronous, active low) clears only the valid bits.
module q24_8_fixed_point_alu #(
    parameter int FRAC_BITS = q24_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = q24_pkg::WORD_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  q24_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output q24_pkg::out_t m_data
);
    import q24_pkg::*;

    localparam int W  = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int NW = W + FRAC_BITS + 1;

    // Advance the whole pipe together; hold it when a result waits untaken.
    logic          en;

    logic          fe_valid;
    side_t         fe_side;
    logic [NW-1:0] fe_num;
    logic [W-1:0]  fe_den;
    logic          fe_neg;

    logic          dv_valid;
    side_t         dv_side;
    logic [NW-1:0] dv_quo;
    logic          dv_neg;

    logic          m_valid_reg;
    logic          m_valid_next;
    out_t          m_data_reg;
    out_t          m_data_next;

    logic [NW-1:0] q_lim;
    logic signed [W-1:0] q_res;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    q24_front #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fe_valid),
        .out_side  (fe_side),
        .out_num   (fe_num),
        .out_den   (fe_den),
        .out_neg   (fe_neg)
    );

    q24_div_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fe_valid),
        .in_side   (fe_side),
        .in_num    (fe_num),
        .in_den    (fe_den),
        .in_neg    (fe_neg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo),
        .out_neg   (dv_neg)
    );

    // Final stage: sign and saturate quotients, zero on divide by zero; others pass.
    always_comb begin
        q_lim = dv_neg ? (NW'(1) << (W-1)) : ((NW'(1) << (W-1)) - NW'(1));
        m_data_next.compare_true   = dv_side.cmp;
        m_data_next.divide_by_zero = dv_side.dz;
        m_data_next.overflow       = dv_side.ovf;
        m_data_next.result         = dv_side.result;
        q_res                      = '0;
        if (dv_side.is_div) begin
            if (dv_side.dz) begin
                m_data_next.overflow = 1'b0;
                m_data_next.result   = '0;
            end else if (dv_quo > q_lim) begin
                m_data_next.overflow = 1'b1;
                q_res = dv_neg ? signed'({1'b1, {(W-1){1'b0}}})
                               : signed'({1'b0, {(W-1){1'b1}}});
                m_data_next.result = FIELD_BITS'(q_res);
            end else begin
                m_data_next.overflow = 1'b0;
                q_res = dv_neg ? signed'(W'(-dv_quo[W-1:0])) : signed'(dv_quo[W-1:0]);
                m_data_next.result = FIELD_BITS'(q_res);
            end
        end
    end

    assign m_valid_next = en ? dv_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the Q24.8 fixed-point ALU (q24_8_fixed_point_alu).
// Depends on q24_pkg for the command codes and the packed in_t / out_t transfers.
`timescale 1ns / 1ps
module tb_top;
    import q24_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    q24_8_fixed_point_alu uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    in_t  pending_ops[$];
    out_t expected_results[$];
    int   errors = 0;
    int   wdog = 0;
    bit   hold_sender = 1'b0;
    bit   s_taken = 1'b0;
    int   s_gap = 0;
    int   m_gap = 0;

    // Saturate a 64-bit signed value to the 32-bit word; flag overflow.
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
                                                   inout logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Compute the result transfer for one command using exact integer math.
    function automatic out_t alu_predict(input in_t op);
        out_t r;
        logic signed [63:0] a, b, p;
        logic [63:0] mg, num, den;
        logic ovf;
        a = op.operand_a;
        b = op.operand_b;
        ovf = 1'b0;
        r = '0;
        case (op.command)
            CMD_ADD: r.result = clamp32(a + b, ovf);
            CMD_SUB: r.result = clamp32(a - b, ovf);
            CMD_MUL: begin
                p = a * b;
                mg = ((p < 0 ? -p : p) + (64'd1 << (FRAC - 1))) >> FRAC;
                r.result = clamp32(p < 0 ? -$signed(mg) : $signed(mg), ovf);
            end
            CMD_DIV: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    num = (a < 0 ? -a : a) << FRAC;
                    den = b < 0 ? -b : b;
                    mg = (num + (den >> 1)) / den;
                    r.result = clamp32(((a < 0) != (b < 0)) ? -$signed(mg) : $signed(mg),
                                       ovf);
                end
            end
            CMD_INC: r.result = clamp32(a + 1, ovf);
            CMD_DEC: r.result = clamp32(a - 1, ovf);
            CMD_GT:  r.compare_true = a > b;
            CMD_LT:  r.compare_true = a < b;
            CMD_LE:  r.compare_true = a <= b;
            CMD_GE:  r.compare_true = a >= b;
            CMD_NE:  r.compare_true = a != b;
            CMD_EQ:  r.compare_true = a == b;
            CMD_MIN: r.result = (a < b) ? a[31:0] : b[31:0];
            CMD_MAX: r.result = (a > b) ? a[31:0] : b[31:0];
            CMD_FROM_INT: r.result = clamp32(a * (64'sd1 <<< FRAC), ovf);
            default: begin
                mg = (a < 0 ? -a : a) >> FRAC;
                r.result = 32'(a < 0 ? -$signed(mg) : $signed(mg));
            end
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    // Mostly no gap, often a short one, and now and then a long one.
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff - $urandom_range(0, 2);
            1: return 32'h80000000 + $urandom_range(0, 2);
            2: return $urandom_range(0, 3) - 1;
            3: return ($urandom_range(0, 2000) - 1000) << FRAC;
            4: return $urandom_range(0, 65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(input logic [3:0] c, input logic [31:0] a, input logic [31:0] b);
        in_t op;
        op.command = c;
        op.operand_a = a;
        op.operand_b = b;
        pending_ops.push_back(op);
    endtask

    // Remember whether the input transfer went through at the last rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_valid && s_ready;
        end
    end

    // Driver: advance the input channel at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_taken) begin
            // hold the current transfer until accepted
        end else if (s_gap > 0) begin
            s_valid <= 1'b0;
            s_gap <= s_gap - 1;
        end else if (!hold_sender && pending_ops.size() > 0) begin
            s_data <= pending_ops.pop_front();
            s_valid <= 1'b1;
            s_gap <= pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result-side stall pattern.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_gap > 0) begin
            m_ready <= 1'b0;
            m_gap <= m_gap - 1;
        end else begin
            m_ready <= 1'b1;
            m_gap <= pick_gap();
        end
    end

    // Monitor: sample both channels at the rising edge, predict and compare.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                wdog <= 0;
            end else begin
                wdog <= wdog + 1;
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(alu_predict(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    errors <= errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== m_data) begin
                        $display("%0t: mismatch expected res=%h cmp=%b ovf=%b dz=%b,",
                                 $time, want.result, want.compare_true, want.overflow,
                                 want.divide_by_zero,
                                 " actual res=%h cmp=%b ovf=%b dz=%b",
                                 m_data.result, m_data.compare_true,
                                 m_data.overflow, m_data.divide_by_zero);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    // Watchdog: drop the run if no transfer happens for too long.
    always @(posedge aclk) begin
        if (wdog >= WDOG_LIMIT) begin
            $display("** q24_8_fixed_point_alu: FAILED **");
            $finish;
        end
    end

    initial begin
        int i;
        logic [3:0] c;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every command at the range ends, plus the named special cases.
        for (i = 0; i < 16; i++) push_op(i[3:0], 32'h7fffffff, 32'h80000000);
        push_op(CMD_DIV, 32'h00000100, 32'h0);            // divide by zero
        push_op(CMD_DIV, 32'h80000000, 32'hffffff00);     // most negative / -1.0
        push_op(CMD_INC, 32'h7fffffff, 32'h0);
        push_op(CMD_DEC, 32'h80000000, 32'h0);
        push_op(CMD_MUL, 32'h00000180, 32'hffffff01);     // rounding halfway
        push_op(CMD_MIN, 32'h00000055, 32'h00000055);
        push_op(CMD_MAX, 32'hffffff80, 32'hffffff80);
        push_op(CMD_TO_INT, 32'hfffffe80, 32'hffffffff);  // -1.5 truncates to -1
        push_op(CMD_FROM_INT, 32'h00800000, 32'h0);

        // Let the directed batch drain completely before the random part.
        wait (pending_ops.size() == 0);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0 && !s_valid);
        hold_sender = 1'b0;

        for (i = 0; i < 1900; i++) begin
            c = 4'($urandom_range(0, 15));
            push_op(c, pick_operand(), ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand());
        end
        wait (pending_ops.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("** q24_8_fixed_point_alu: PASSED **");
        end else begin
            $display("** q24_8_fixed_point_alu: FAILED **");
        end
        $finish;
    end
endmodule

// File: filelist.f
sv/q24_pkg.sv
sv/q24_front.sv
sv/q24_div_pipe.sv
sv/q24_8_fixed_point_alu.sv
tb/sv/tb_top.sv
